/* rtl/core/pwtx_pkg.sv */
// shared types and constants for the pulse width one wire transmitter
`default_nettype none

package pwtx_pkg;

  // field widths
  localparam int unsigned ByteW = 8;
  localparam int unsigned DurW  = 16;

  // segment counts per byte
  localparam int unsigned BitSegs = 2 * ByteW;
  localparam int unsigned SegMax  = BitSegs + 2;
  localparam int unsigned CntW    = $clog2(SegMax);

  // register reset values
  localparam logic [DurW-1:0] LongResetUs     = DurW'(1200);
  localparam logic [DurW-1:0] ShortResetUs    = DurW'(400);
  localparam logic [DurW-1:0] PreambleResetUs = DurW'(5000);

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_LONG_PULSE  = 2'd0,
    CFG_SHORT_PULSE = 2'd1,
    CFG_PREAMBLE    = 2'd2
  } cfg_idx_e;

  // current timing settings
  typedef struct packed {
    logic [DurW-1:0] long_us;
    logic [DurW-1:0] short_us;
    logic [DurW-1:0] preamble_us;
  } timing_t;

  // one line segment
  typedef struct packed {
    logic            line_level;
    logic [DurW-1:0] duration_us;
    logic            seg_last;
  } seg_t;

endpackage

`default_nettype wire

/* rtl/core/pwtx_cfg_regs.sv */
// timing configuration registers
`default_nettype none

module pwtx_cfg_regs
  import pwtx_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [DurW-1:0]    cfg_wdata_i,
  output timing_t                 timing_o
);

  timing_t timing_q;

  // register write, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timing_q.long_us     <= LongResetUs;
      timing_q.short_us    <= ShortResetUs;
      timing_q.preamble_us <= PreambleResetUs;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LONG_PULSE:  timing_q.long_us     <= cfg_wdata_i;
        CFG_SHORT_PULSE: timing_q.short_us    <= cfg_wdata_i;
        CFG_PREAMBLE:    timing_q.preamble_us <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign timing_o = timing_q;

endmodule

`default_nettype wire

/* rtl/core/pwtx_seg_gen.sv */
// byte holding register and segment sequencer
`default_nettype none

module pwtx_seg_gen
  import pwtx_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [ByteW-1:0] cmd_byte_i,
  input  wire logic             end_of_frame_i,
  input  timing_t               timing_i,
  input  wire logic             out_free_i,
  output logic                  seg_valid_o,
  output seg_t                  seg_o
);

  logic             busy_q;
  logic [CntW-1:0]  cnt_q;
  logic             frame_open_q;
  logic [ByteW-1:0] byte_q;
  logic             eof_q;
  logic             pre_q;

  logic             in_fire;
  logic             seg_fire;
  logic [CntW-1:0]  k;
  logic [CntW-1:0]  last_idx;
  logic             bit_val;
  logic             half;
  seg_t             seg;

  // segment for the current count
  always_comb begin
    k        = cnt_q - CntW'(pre_q);
    last_idx = CntW'(BitSegs - 1) + CntW'(pre_q) + CntW'(eof_q);
    bit_val  = byte_q[k[3:1]];
    half     = k[0];
    seg.seg_last = (cnt_q == last_idx);
    if (pre_q && (cnt_q == '0)) begin
      seg.line_level  = 1'b0;
      seg.duration_us = timing_i.preamble_us;
    end else if (k < CntW'(BitSegs)) begin
      // high half first, long half carries the bit value
      seg.line_level  = ~half;
      seg.duration_us = (bit_val ^ half) ? timing_i.long_us : timing_i.short_us;
    end else begin
      // idle high after the frame's last byte
      seg.line_level  = 1'b1;
      seg.duration_us = '0;
    end
  end

  // handshake, next byte loads as the last segment leaves
  assign seg_fire   = busy_q && out_free_i;
  assign in_ready_o = !busy_q || (seg_fire && seg.seg_last);
  assign in_fire    = in_valid_i && in_ready_o;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      cnt_q        <= '0;
      frame_open_q <= 1'b0;
      pre_q        <= 1'b0;
      eof_q        <= 1'b0;
    end else if (in_fire) begin
      busy_q       <= 1'b1;
      cnt_q        <= '0;
      pre_q        <= !frame_open_q;
      eof_q        <= end_of_frame_i;
      frame_open_q <= !end_of_frame_i;
    end else if (seg_fire) begin
      if (seg.seg_last) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + CntW'(1);
      end
    end
  end

  // byte payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      byte_q <= cmd_byte_i;
    end
  end

  assign seg_valid_o = seg_fire;
  assign seg_o       = seg;

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q < CntW'(SegMax)))
    else $error("segment count out of range");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seg_fire && seg.seg_last && !in_fire) |=> !busy_q)
    else $error("sequencer still busy after last segment");

  a_eof_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && end_of_frame_i) |=> !frame_open_q)
    else $error("frame left open after end of frame beat");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seg_fire && !seg.seg_last) |=> (busy_q && (cnt_q == $past(cnt_q) + CntW'(1))))
    else $error("segment count did not advance");
`endif

endmodule

`default_nettype wire

/* rtl/core/pwtx_out_reg.sv */
// segment output register
`default_nettype none

module pwtx_out_reg
  import pwtx_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            seg_valid_i,
  input  seg_t                 seg_i,
  output logic                 free_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic                 line_level_o,
  output logic [DurW-1:0]      duration_us_o,
  output logic                 seg_last_o
);

  logic valid_q;
  seg_t seg_q;

  // register can load when empty or draining this cycle
  assign free_o = !valid_q || out_ready_i;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= seg_valid_i;
    end
  end

  // segment payload
  always_ff @(posedge clk_i) begin
    if (free_o && seg_valid_i) begin
      seg_q <= seg_i;
    end
  end

  assign out_valid_o   = valid_q;
  assign line_level_o  = seg_q.line_level;
  assign duration_us_o = seg_q.duration_us;
  assign seg_last_o    = seg_q.seg_last;

endmodule

`default_nettype wire

/* rtl/core/pulse_width_one_wire_tx.sv */
// Pulse width one wire transmitter top level. Each accepted beat carries one command byte
// and an end of frame flag and yields 16 to 18 line segments (level plus duration in us):
// a low preamble when no frame is open, two segments per bit LSB first (one = long high,
// short low; zero = short high, long low), and an idle high segment of duration 0 after
// an end of frame byte, which closes the frame. Segments leave one per cycle through a
// single output register while the sink keeps ready high; the next byte is taken in the
// cycle its predecessor's last segment loads into the output register, so there is no
// gap between bytes. After a byte is accepted, its first segment is formed from the byte
// register and passes through the output register to the outputs. Timing registers take
// effect at once and should only be written while no byte is in flight.
`default_nettype none

module pulse_width_one_wire_tx
  import pwtx_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [DurW-1:0]    cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [ByteW-1:0]   cmd_byte_i,
  input  wire logic               end_of_frame_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    line_level_o,
  output logic [DurW-1:0]         duration_us_o,
  output logic                    seg_last_o
);

  timing_t timing;
  logic    out_free;
  logic    seg_valid;
  seg_t    seg;

  // timing registers
  pwtx_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .timing_o    (timing)
  );

  // byte register and sequencer
  pwtx_seg_gen u_seg_gen (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_byte_i     (cmd_byte_i),
    .end_of_frame_i (end_of_frame_i),
    .timing_i       (timing),
    .out_free_i     (out_free),
    .seg_valid_o    (seg_valid),
    .seg_o          (seg)
  );

  // output register
  pwtx_out_reg u_out_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .seg_valid_i   (seg_valid),
    .seg_i         (seg),
    .free_o        (out_free),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .line_level_o  (line_level_o),
    .duration_us_o (duration_us_o),
    .seg_last_o    (seg_last_o)
  );

endmodule

`default_nettype wire
